// File: src/vdi_pkg.sv
// Shared types and constants for the vertex de-duplication indexer.
package vdi_pkg;

   localparam int WORD_BITS        = 32;
   localparam int WORDS_PER_VERTEX = 7;
   localparam int VERTEX_BITS      = WORD_BITS * WORDS_PER_VERTEX;
   localparam int INDEX_BITS       = 8;

   typedef logic [WORD_BITS-1:0] word_type;

   // One stored vertex: position then color, raw bit patterns.
   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type color_r;
      word_type color_g;
      word_type color_b;
      word_type color_a;
   } vertex_type;

   // Result beat as held in the output register.
   typedef struct packed {
      logic [INDEX_BITS-1:0] vertex_index;
      logic                  is_new;
      logic                  overflow;
      logic                  topology;
   } result_type;

endpackage

// File: src/vdi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/vertex_dedup_indexer.sv
// Vertex de-duplication indexer: scans a vertex store for an exact match, appends on miss.
// The scan reads entries 0..N-1 in order, N = vertex count at acceptance, and compares
//   each read against the request; a hit on entry k ends the scan early.
// No new vertex is taken until the last result is loaded; an unread result stalls the scan.
// Reset clears the vertex count, the scan control and the result valid flag; the
// store itself is not cleared, since only entries below the count are ever read.
module vertex_dedup_indexer #(
   parameter int VERTEX_CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_color_r,
   input  logic [31:0] req_color_g,
   input  logic [31:0] req_color_b,
   input  logic [31:0] req_color_a,
   input  logic        req_topology,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [vdi_pkg::INDEX_BITS-1:0] rsp_vertex_index,
   output logic        rsp_is_new,
   output logic        rsp_overflow,
   output logic        rsp_topology_out
);
   import vdi_pkg::*;

   // Address bits for the store, count bits able to hold the capacity itself.
   localparam int AW = (VERTEX_CAPACITY > 1) ? $clog2(VERTEX_CAPACITY) : 1;
   localparam int CW = $clog2(VERTEX_CAPACITY + 1);
   // Index widened so the low byte can always be taken.
   localparam int IW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
   localparam logic [CW-1:0] CAP = CW'(VERTEX_CAPACITY);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type        state_ff, state_in;
   vertex_type       vtx_ff, vtx_in;
   logic             topo_ff, topo_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    issue_ff, issue_in;    // next entry to read
   logic             pend_ff, pend_in;      // a read is in flight
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             req_beat;
   logic             stall;
   logic             step;
   logic             issue;
   logic             hit;
   logic             miss_done;
   logic             has_room;
   logic             res_load;
   logic             ram_wr_en;
   logic             ram_rd_en;
   vertex_type       ram_rd_data;
   logic [IW-1:0]    hit_idx_w;
   logic [IW-1:0]    new_idx_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;

   // Hold the whole scan while a finished result still sits unread.
   assign stall     = rsp_valid_ff && !rsp_ready;
   assign step      = (state_ff == ST_SCAN) && !stall;
   assign issue     = (issue_ff < count_ff);
   assign hit       = pend_ff && (ram_rd_data == vtx_ff);
   assign miss_done = !issue && !hit;
   assign has_room  = (count_ff < CAP);
   assign res_load  = step && (hit || miss_done);

   assign ram_rd_en = step && issue && !hit;
   assign ram_wr_en = step && miss_done && has_room;

   assign hit_idx_w = IW'(pend_idx_ff);
   assign new_idx_w = IW'(count_ff[AW-1:0]);

   vdi_ram #(
      .WIDTH (VERTEX_BITS),
      .DEPTH (VERTEX_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (vtx_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      vtx_in       = vtx_ff;
      topo_in      = topo_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               vtx_in.pos_x   = req_pos_x;
               vtx_in.pos_y   = req_pos_y;
               vtx_in.pos_z   = req_pos_z;
               vtx_in.color_r = req_color_r;
               vtx_in.color_g = req_color_g;
               vtx_in.color_b = req_color_b;
               vtx_in.color_a = req_color_a;
               topo_in        = req_topology;
               issue_in       = '0;
               pend_in        = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step) begin
               // Read pipeline: address issued now, compared once the registered read data returns.
               pend_in     = ram_rd_en;
               pend_idx_in = issue_ff[AW-1:0];
               if (ram_rd_en) begin
                  issue_in = issue_ff + CW'(1);
               end
               if (res_load) begin
                  state_in        = ST_IDLE;
                  pend_in         = 1'b0;
                  rsp_valid_in    = 1'b1;
                  rsp_in.topology = topo_ff;
                  if (hit) begin
                     rsp_in.vertex_index = hit_idx_w[INDEX_BITS-1:0];
                     rsp_in.is_new       = 1'b0;
                     rsp_in.overflow     = 1'b0;
                  end else if (has_room) begin
                     rsp_in.vertex_index = new_idx_w[INDEX_BITS-1:0];
                     rsp_in.is_new       = 1'b1;
                     rsp_in.overflow     = 1'b0;
                     count_in            = count_ff + CW'(1);
                  end else begin
                     // store full and nothing matched
                     rsp_in.vertex_index = '0;
                     rsp_in.is_new       = 1'b0;
                     rsp_in.overflow     = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vtx_ff      <= vtx_in;
      topo_ff     <= topo_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_ff.vertex_index;
   assign rsp_is_new       = rsp_ff.is_new;
   assign rsp_overflow     = rsp_ff.overflow;
   assign rsp_topology_out = rsp_ff.topology;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("vertex count above capacity");

   a_new_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.is_new && rsp_ff.overflow))
      else $error("result both new and overflow");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not advance count");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SCAN)
      else $error("read in flight outside scan");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for vertex_dedup_indexer: directed corner cases, then random vertex streams.
module tb_top;
   import vdi_pkg::*;

   localparam int VERTEX_CAPACITY = 256;
   localparam int IDLE_PCT        = 37;      // chance per cycle that a side idles
   localparam int FILL_BEATS      = 720;     // random beats while the store fills up
   localparam int FULL_BEATS      = 710;     // random beats against a full store
   localparam int STEADY_BEATS    = 250;     // no idling on either side for these
   // Worst case is ~1450 beats, each a full scan of the store plus stalls; allow about 5x that.
   localparam int CYCLE_LIMIT     = 2_000_000;

   // Float bit patterns of interest
   localparam word_type NEG_ZERO   = 32'h8000_0000;
   localparam word_type ALL_ONES   = 32'hFFFF_FFFF;
   localparam word_type QUIET_NAN  = 32'h7FC0_0000;
   localparam word_type SIGNAL_NAN = 32'h7F80_0001;

   localparam logic TOPO_TRIANGLE = 1'b0;
   localparam logic TOPO_LINE     = 1'b1;

   // All inputs start at known values.
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   word_type    req_pos_x    = '0;
   word_type    req_pos_y    = '0;
   word_type    req_pos_z    = '0;
   word_type    req_color_r  = '0;
   word_type    req_color_g  = '0;
   word_type    req_color_b  = '0;
   word_type    req_color_a  = '0;
   logic        req_topology = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic [INDEX_BITS-1:0] rsp_vertex_index;
   logic        rsp_is_new;
   logic        rsp_overflow;
   logic        rsp_topology_out;

   // Shadow of the unique-vertex store, in insertion order.
   vertex_type  known_vertices[$];
   // Every vertex accepted so far, used for repeats (stored or overflowed).
   vertex_type  sent_history[$];
   // Index results predicted but not yet seen on the rsp side, oldest first.
   result_type  index_results_due[$];

   logic        steady_flow     = 1'b0;
   int          fail_count      = 0;
   int          results_checked = 0;
   int          appended_count  = 0;
   int          matched_count   = 0;
   int          overflow_count  = 0;
   int          cycle_count     = 0;

   vertex_dedup_indexer #(
      .VERTEX_CAPACITY (VERTEX_CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_color_r      (req_color_r),
      .req_color_g      (req_color_g),
      .req_color_b      (req_color_b),
      .req_color_a      (req_color_a),
      .req_topology     (req_topology),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_overflow     (rsp_overflow),
      .rsp_topology_out (rsp_topology_out)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------
   // Vertex helpers. Word 0 (pos_x) sits at the top of the packed vertex.
   // ---------------------------------------------------------------
   function automatic vertex_type with_word(vertex_type v, int k, word_type w);
      logic [VERTEX_BITS-1:0] bits;
      bits = v;
      bits[VERTEX_BITS-1-WORD_BITS*k -: WORD_BITS] = w;
      return bits;
   endfunction

   function automatic vertex_type flip_bit(vertex_type v, int b);
      logic [VERTEX_BITS-1:0] bits;
      bits = v;
      bits[b] = ~bits[b];
      return bits;
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      v = '0;
      for (int k = 0; k < WORDS_PER_VERTEX; k++) begin
         v = with_word(v, k, $urandom());
      end
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Index predictor: first exact 224-bit match in insertion order wins;
   // on a miss append if there is room, else flag overflow with index 0.
   // ---------------------------------------------------------------
   function automatic result_type lookup_vertex(vertex_type v, logic topo);
      result_type r;
      r = '0;
      r.topology = topo;
      foreach (known_vertices[i]) begin
         if (known_vertices[i] == v) begin
            r.vertex_index = INDEX_BITS'(i);
            matched_count++;
            return r;
         end
      end
      if (known_vertices.size() >= VERTEX_CAPACITY) begin
         r.overflow = 1'b1;
         overflow_count++;
         return r;
      end
      r.vertex_index = INDEX_BITS'(known_vertices.size());
      r.is_new = 1'b1;
      known_vertices = {known_vertices, v};
      appended_count++;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request side: optional random gap, then hold the beat until accepted.
   // Valid is only lowered during a gap, so back-to-back beats keep it high.
   // ---------------------------------------------------------------
   task automatic send_vertex(input vertex_type v, input logic topo);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pos_x    <= v.pos_x;
      req_pos_y    <= v.pos_y;
      req_pos_z    <= v.pos_z;
      req_color_r  <= v.color_r;
      req_color_g  <= v.color_g;
      req_color_b  <= v.color_b;
      req_color_a  <= v.color_a;
      req_topology <= topo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge; results come back in order
      index_results_due = {index_results_due, lookup_vertex(v, topo)};
      sent_history = {sent_history, v};
   endtask

   // ---------------------------------------------------------------
   // Response side: random backpressure, none during the steady stretch.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   // Result checker: every accepted rsp beat against the oldest prediction.
   always @(posedge clock) begin
      result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (index_results_due.size() == 0) begin
            $error("unexpected result beat: vertex_index %0d is_new %0b overflow %0b",
                   rsp_vertex_index, rsp_is_new, rsp_overflow);
            fail_count++;
         end else begin
            due = index_results_due.pop_front();
            results_checked++;
            if (rsp_vertex_index !== due.vertex_index) begin
               $error("vertex_index: expected %0d, actual %0d",
                      due.vertex_index, rsp_vertex_index);
               fail_count++;
            end
            if (rsp_is_new !== due.is_new) begin
               $error("is_new: expected %0b, actual %0b", due.is_new, rsp_is_new);
               fail_count++;
            end
            if (rsp_overflow !== due.overflow) begin
               $error("overflow: expected %0b, actual %0b", due.overflow, rsp_overflow);
               fail_count++;
            end
            if (rsp_topology_out !== due.topology) begin
               $error("topology_out: expected %0b, actual %0b",
                      due.topology, rsp_topology_out);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------

   // All-zero and all-one words, both topologies, first hits on entries 0 and 1.
   task automatic test_extreme_words();
      vertex_type zeros;
      vertex_type ones;
      zeros = '0;
      ones  = '1;
      send_vertex(zeros, TOPO_TRIANGLE);
      send_vertex(ones, TOPO_LINE);
      send_vertex(zeros, TOPO_LINE);
      send_vertex(ones, TOPO_TRIANGLE);
   endtask

   // -0.0 must not match +0.0 in any of the seven words.
   task automatic test_signed_zero();
      vertex_type v;
      for (int k = 0; k < WORDS_PER_VERTEX; k++) begin
         v = with_word('0, k, NEG_ZERO);
         send_vertex(v, TOPO_TRIANGLE);
      end
      // repeat of the -0.0 x vertex is a hit
      send_vertex(with_word('0, 0, NEG_ZERO), TOPO_LINE);
   endtask

   // NaN patterns compare as bits: identical NaN matches, other payload does not.
   task automatic test_nan_patterns();
      vertex_type nan_v;
      vertex_type other_nan;
      nan_v = '0;
      for (int k = 0; k < WORDS_PER_VERTEX; k++) begin
         nan_v = with_word(nan_v, k, QUIET_NAN);
      end
      other_nan = with_word(nan_v, 1, SIGNAL_NAN);
      send_vertex(nan_v, TOPO_TRIANGLE);
      send_vertex(nan_v, TOPO_LINE);
      send_vertex(other_nan, TOPO_LINE);
      send_vertex(other_nan, TOPO_TRIANGLE);
   endtask

   // One flipped bit in each word of the all-ones vertex: every one a miss.
   task automatic test_single_bit_miss();
      vertex_type ones;
      ones = with_word('1, 0, ALL_ONES);
      for (int k = 0; k < WORDS_PER_VERTEX; k++) begin
         send_vertex(flip_bit(ones, WORD_BITS*k + $urandom_range(WORD_BITS-1)),
                     1'($urandom_range(1)));
      end
   endtask

   // ---------------------------------------------------------------
   // Random tests
   // ---------------------------------------------------------------

   // Fresh vertices, repeats and near misses until well past full.
   task automatic test_random_fill();
      int         pick;
      vertex_type v;
      for (int n = 0; n < FILL_BEATS; n++) begin
         pick = $urandom_range(99);
         if (pick < 50 || known_vertices.size() == 0) begin
            v = random_vertex();
         end else if (pick < 85) begin
            v = sent_history[$urandom_range(sent_history.size()-1)];
         end else begin
            v = flip_bit(known_vertices[$urandom_range(known_vertices.size()-1)],
                         $urandom_range(VERTEX_BITS-1));
         end
         send_vertex(v, 1'($urandom_range(1)));
      end
   endtask

   // Full store: hits (first and last entries among them) and overflow misses.
   // The first stretch runs with no idling on either side.
   task automatic test_full_store();
      int         pick;
      int         sel;
      int         slot;
      vertex_type v;
      for (int n = 0; n < FULL_BEATS; n++) begin
         steady_flow <= (n < STEADY_BEATS);
         pick = $urandom_range(99);
         if (pick < 40) begin
            sel = $urandom_range(9);
            if (sel == 0) begin
               slot = 0;
            end else if (sel == 1) begin
               slot = known_vertices.size() - 1;
            end else begin
               slot = $urandom_range(known_vertices.size()-1);
            end
            v = known_vertices[slot];
         end else if (pick < 70) begin
            v = random_vertex();
         end else if (pick < 85) begin
            v = flip_bit(known_vertices[$urandom_range(known_vertices.size()-1)],
                         $urandom_range(VERTEX_BITS-1));
         end else begin
            v = sent_history[$urandom_range(sent_history.size()-1)];
         end
         send_vertex(v, 1'($urandom_range(1)));
      end
      steady_flow <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_extreme_words();
      test_signed_zero();
      test_nan_patterns();
      test_single_bit_miss();
      test_random_fill();
      test_full_store();
      req_valid <= 1'b0;

      // drain: wait for every predicted result, then a full scan's worth more
      while (index_results_due.size() != 0) @(posedge clock);
      repeat (VERTEX_CAPACITY + 8) @(posedge clock);

      $display("%0d index results checked: %0d appended, %0d matched, %0d overflowed",
               results_checked, appended_count, matched_count, overflow_count);
      $display("store ended with %0d of %0d entries; both sides stalled at random",
               known_vertices.size(), VERTEX_CAPACITY);
      if (fail_count == 0) begin
         $display("** vertex_dedup_indexer: PASSED **");
      end else begin
         $display("** vertex_dedup_indexer: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, index_results_due.size());
      $display("** vertex_dedup_indexer: FAILED **");
      $finish;
   end

endmodule

// File: vertex_dedup_indexer.f
src/vdi_pkg.sv
src/vdi_ram.sv
src/vertex_dedup_indexer.sv
sim/tb_top.sv
